@@ rtl/sdspi_pkg.sv @@
// Package for the SD card SPI command engine: sizes, request kinds, phase codes
// and the request/result structs shared by the engine and the top level.
// No dependencies.
package sdspi_pkg;

    localparam int HALF_PERIOD_W  = 16;
    localparam int POLL_LIMIT_DEF = 9;
    localparam int WAIT_WIDTH_DEF = 16;
    localparam int BYTE_COUNT_ARG = 4;

    localparam logic [7:0] CMD_START = 8'h40;
    localparam logic [7:0] FILL_BYTE = 8'hff;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_TICK     = 3'd0;
    localparam kind_t KIND_SET_CS   = 3'd1;
    localparam kind_t KIND_CMD_FILL = 3'd2;
    localparam kind_t KIND_CMD_CRC  = 3'd3;
    localparam kind_t KIND_WRITE    = 3'd4;
    localparam kind_t KIND_READ     = 3'd5;
    localparam kind_t KIND_CLOCK    = 3'd6;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_CMD_FILL = 8'b0000_0010,
        PH_CMD_CRC  = 8'b0000_0100,
        PH_FILLER   = 8'b0000_1000,
        PH_POLL     = 8'b0001_0000,
        PH_WRITE    = 8'b0010_0000,
        PH_READ     = 8'b0100_0000,
        PH_CLOCK    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        chip_select;
        logic [7:0]  tx_byte;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [7:0]  extra_filler;
        logic        miso;
    } req_t;

    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic       cs_n;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       accepted;
    } res_t;

endpackage

@@ rtl/sdspi_engine.sv @@
// SPI bit/byte sequencer for the SD card command engine: one tick per step.
// Holds pin levels, shift registers and timing counters; result is combinational.
// Depends on sdspi_pkg.
module sdspi_engine #(
    parameter int POLL_LIMIT = sdspi_pkg::POLL_LIMIT_DEF,
    parameter int WAIT_WIDTH = sdspi_pkg::WAIT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  sdspi_pkg::req_t                       req,
    input  logic [sdspi_pkg::HALF_PERIOD_W-1:0]   half_period,
    output sdspi_pkg::res_t                       res
);

    sdspi_pkg::phase_t     phase_reg, phase_next;
    logic [2:0]            byte_index_reg, byte_index_next;
    logic [2:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_out_reg, shift_out_next;
    logic [7:0]            shift_in_reg, shift_in_next;
    logic [WAIT_WIDTH-1:0] wait_count_reg, wait_count_next;
    logic [3:0]            poll_count_reg, poll_count_next;
    logic [7:0]            filler_left_reg, filler_left_next;
    logic [31:0]           held_argument_reg, held_argument_next;
    logic                  cs_level_reg, cs_level_next;
    logic                  clock_level_reg, clock_level_next;

    logic [WAIT_WIDTH-1:0] load_wait;
    logic                  start;
    logic [7:0]            start_val;
    logic [7:0]            sin;
    logic [3:0]            poll_inc;
    logic                  done;
    logic [7:0]            rx;
    logic                  acc;

    generate
        if (WAIT_WIDTH >= sdspi_pkg::HALF_PERIOD_W) begin : g_wide_wait
            assign load_wait = WAIT_WIDTH'(half_period);
        end
        else begin : g_narrow_wait
            assign load_wait = (|half_period[sdspi_pkg::HALF_PERIOD_W-1:WAIT_WIDTH])
                             ? '1 : half_period[WAIT_WIDTH-1:0];
        end
    endgenerate

    assign sin      = {shift_in_reg[6:0], req.miso};
    assign poll_inc = poll_count_reg + 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        bit_count_next     = bit_count_reg;
        shift_out_next     = shift_out_reg;
        shift_in_next      = shift_in_reg;
        wait_count_next    = wait_count_reg;
        poll_count_next    = poll_count_reg;
        filler_left_next   = filler_left_reg;
        held_argument_next = held_argument_reg;
        cs_level_next      = cs_level_reg;
        clock_level_next   = clock_level_reg;
        start              = 1'b0;
        start_val          = sdspi_pkg::FILL_BYTE;
        done               = 1'b0;
        rx                 = 8'd0;
        acc                = 1'b0;

        if (phase_reg == sdspi_pkg::PH_IDLE) begin
            unique case (req.kind)
                sdspi_pkg::KIND_SET_CS:
                begin
                    cs_level_next = ~req.chip_select;
                    acc           = 1'b1;
                    done          = 1'b1;
                end
                sdspi_pkg::KIND_CMD_FILL, sdspi_pkg::KIND_CMD_CRC:
                begin
                    held_argument_next = req.argument;
                    byte_index_next    = 3'd0;
                    poll_count_next    = 4'd0;
                    if (req.kind == sdspi_pkg::KIND_CMD_FILL) begin
                        filler_left_next = req.extra_filler;
                        phase_next       = sdspi_pkg::PH_CMD_FILL;
                    end
                    else begin
                        filler_left_next = req.tx_byte;
                        phase_next       = sdspi_pkg::PH_CMD_CRC;
                    end
                    start     = 1'b1;
                    start_val = sdspi_pkg::CMD_START | {2'b00, req.command_index};
                    acc       = 1'b1;
                end
                sdspi_pkg::KIND_WRITE:
                begin
                    phase_next = sdspi_pkg::PH_WRITE;
                    start      = 1'b1;
                    start_val  = req.tx_byte;
                    acc        = 1'b1;
                end
                sdspi_pkg::KIND_READ:
                begin
                    phase_next = sdspi_pkg::PH_READ;
                    start      = 1'b1;
                    acc        = 1'b1;
                end
                sdspi_pkg::KIND_CLOCK:
                begin
                    phase_next = sdspi_pkg::PH_CLOCK;
                    start      = 1'b1;
                    acc        = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (wait_count_reg != '0) begin
            wait_count_next = wait_count_reg - 1'b1;
        end
        else if (!clock_level_reg) begin
            clock_level_next = 1'b1;
            wait_count_next  = load_wait;
        end
        else begin
            shift_in_next  = sin;
            shift_out_next = {shift_out_reg[6:0], 1'b1};
            if (bit_count_reg != 3'd7) begin
                bit_count_next   = bit_count_reg + 3'd1;
                clock_level_next = 1'b0;
                wait_count_next  = load_wait;
            end
            else begin
                unique case (phase_reg)
                    sdspi_pkg::PH_CMD_FILL, sdspi_pkg::PH_CMD_CRC:
                    begin
                        start = 1'b1;
                        if (byte_index_reg < 3'(sdspi_pkg::BYTE_COUNT_ARG)) begin
                            start_val          = held_argument_reg[31:24];
                            held_argument_next = {held_argument_reg[23:0], 8'd0};
                            byte_index_next    = byte_index_reg + 3'd1;
                        end
                        else if (byte_index_reg == 3'(sdspi_pkg::BYTE_COUNT_ARG)) begin
                            if (phase_reg == sdspi_pkg::PH_CMD_CRC) begin
                                start_val        = filler_left_reg;
                                filler_left_next = 8'd0;
                            end
                            byte_index_next = 3'(sdspi_pkg::BYTE_COUNT_ARG + 1);
                        end
                        else begin
                            poll_count_next = 4'd0;
                            if (phase_reg == sdspi_pkg::PH_CMD_FILL && filler_left_reg != 8'd0)
                                phase_next = sdspi_pkg::PH_FILLER;
                            else
                                phase_next = sdspi_pkg::PH_POLL;
                        end
                    end
                    sdspi_pkg::PH_FILLER:
                    begin
                        filler_left_next = filler_left_reg - 8'd1;
                        if (filler_left_reg == 8'd1)
                            phase_next = sdspi_pkg::PH_POLL;
                        start = 1'b1;
                    end
                    sdspi_pkg::PH_POLL:
                    begin
                        poll_count_next = poll_inc;
                        if (sin != sdspi_pkg::FILL_BYTE || poll_inc >= 4'(POLL_LIMIT)) begin
                            done       = 1'b1;
                            rx         = sin;
                            phase_next = sdspi_pkg::PH_IDLE;
                        end
                        else begin
                            start = 1'b1;
                        end
                    end
                    sdspi_pkg::PH_READ:
                    begin
                        done       = 1'b1;
                        rx         = sin;
                        phase_next = sdspi_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        done       = 1'b1;
                        phase_next = sdspi_pkg::PH_IDLE;
                    end
                endcase
            end
        end

        if (start) begin
            shift_out_next   = start_val;
            shift_in_next    = 8'd0;
            bit_count_next   = (phase_reg == sdspi_pkg::PH_IDLE
                                && req.kind == sdspi_pkg::KIND_CLOCK) ? 3'd7 : 3'd0;
            clock_level_next = 1'b0;
            wait_count_next  = load_wait;
        end
    end

    always_comb
    begin
        res.sclk     = clock_level_next;
        res.mosi     = (phase_next == sdspi_pkg::PH_IDLE) ? 1'b1 : shift_out_next[7];
        res.cs_n     = cs_level_next;
        res.busy_res = (phase_next != sdspi_pkg::PH_IDLE);
        res.done_res = done;
        res.rx_byte  = rx;
        res.accepted = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= sdspi_pkg::PH_IDLE;
            byte_index_reg    <= 3'd0;
            bit_count_reg     <= 3'd0;
            shift_out_reg     <= 8'hff;
            shift_in_reg      <= 8'd0;
            wait_count_reg    <= '0;
            poll_count_reg    <= 4'd0;
            filler_left_reg   <= 8'd0;
            held_argument_reg <= 32'd0;
            cs_level_reg      <= 1'b1;
            clock_level_reg   <= 1'b0;
        end
        else if (step) begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            bit_count_reg     <= bit_count_next;
            shift_out_reg     <= shift_out_next;
            shift_in_reg      <= shift_in_next;
            wait_count_reg    <= wait_count_next;
            poll_count_reg    <= poll_count_next;
            filler_left_reg   <= filler_left_next;
            held_argument_reg <= held_argument_next;
            cs_level_reg      <= cs_level_next;
            clock_level_reg   <= clock_level_next;
        end
    end

    a_byte_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= 3'(sdspi_pkg::BYTE_COUNT_ARG + 1))
        else $error("byte index out of range");

    a_poll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        poll_count_reg <= 4'(POLL_LIMIT))
        else $error("poll count beyond limit");

    a_filler_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sdspi_pkg::PH_FILLER |-> filler_left_reg != 8'd0)
        else $error("filler phase with no filler left");

    a_busy_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != sdspi_pkg::PH_IDLE |-> !res.accepted)
        else $error("request taken while busy");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == sdspi_pkg::PH_IDLE)
        else $error("done without returning to idle");

endmodule

@@ rtl/sd_spi_command_engine.sv @@
// Top level of the SD card SPI command engine: stream handshake, output register,
// half period configuration register. Depends on sdspi_pkg and sdspi_engine.
//
// channel | dir | signals                        | transaction content
// s       | in  | s_tvalid s_tready s_tdata s_tuser | one tick with optional request
// m       | out | m_tvalid m_tready m_tdata        | pin levels and status after tick
// cfg     | in  | cfg_valid cfg_ready cfg_data     | half_period write
//
// One input transaction per cycle while s_tready is high; its result sits in the output
// register in the next cycle. The engine state advances only on an accepted transaction.
// s_tready drops only while a result waits and m_tready is low.
// Reset: chip select released, engine idle, half_period zero, no result pending.
module sd_spi_command_engine #(
    parameter int POLL_LIMIT = sdspi_pkg::POLL_LIMIT_DEF,
    parameter int WAIT_WIDTH = sdspi_pkg::WAIT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // chip_select[0] tx_byte[8:1] command_index[14:9] argument[46:15]
    // extra_filler[54:47] miso[55]
    input  logic [55:0]                         s_tdata,
    // kind[2:0]
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sclk[0] mosi[1] cs_n[2] busy_res[3] done_res[4] rx_byte[12:5]
    // accepted[13] zero[15:14]
    output logic [15:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdspi_pkg::HALF_PERIOD_W-1:0] cfg_data
);

    logic [sdspi_pkg::HALF_PERIOD_W-1:0] half_period_reg;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [15:0]                         m_tdata_reg;
    logic                                step;
    sdspi_pkg::req_t                     req;
    sdspi_pkg::res_t                     res;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        req.kind          = s_tuser;
        req.chip_select   = s_tdata[0];
        req.tx_byte       = s_tdata[8:1];
        req.command_index = s_tdata[14:9];
        req.argument      = s_tdata[46:15];
        req.extra_filler  = s_tdata[54:47];
        req.miso          = s_tdata[55];
    end

    sdspi_engine #(
        .POLL_LIMIT (POLL_LIMIT),
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .req         (req),
        .half_period (half_period_reg),
        .res         (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (step)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_period_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
                half_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            m_tdata_reg <= {2'b00, res.accepted, res.rx_byte, res.done_res, res.busy_res,
                            res.cs_n, res.mosi, res.sclk};
    end

endmodule

@@ sim/sd_spi_command_engine_tb.sv @@
// Self-checking testbench for sd_spi_command_engine: drives tick transactions with
// optional requests, predicts pin levels and status per tick, checks every result.
// Depends on sdspi_pkg and the RTL of the engine.
module sd_spi_command_engine_tb;
    import sdspi_pkg::*;

    localparam kind_t KIND_UNUSED = 3'd7;
    localparam res_t  NO_RES      = '0;

    typedef struct {
        req_t rq;
        int   resp;
        bit   run;
        bit   typed;
        res_t want;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    sd_spi_command_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predicted engine state
    logic [15:0] half_r;
    phase_t      ph;
    logic [2:0]  byte_idx;
    logic [2:0]  bit_cnt;
    logic [7:0]  sh_out;
    logic [7:0]  sh_in;
    logic [15:0] wait_cnt;
    logic [3:0]  polls;
    logic [7:0]  fill_left;
    logic [31:0] arg_hold;
    logic        cs_lvl;
    logic        clk_lvl;

    res_t      pending_pins[$];
    step_row_t steps[$];
    int        resp_wait;
    int        mism;
    int        n_items;
    int        n_taken;
    int        n_cmds;
    int        n_cfg;
    bit        gappy;
    bit        calm;

    function void pins_reset();
        half_r    = '0;
        ph        = PH_IDLE;
        byte_idx  = '0;
        bit_cnt   = '0;
        sh_out    = 8'hff;
        sh_in     = '0;
        wait_cnt  = '0;
        polls     = '0;
        fill_left = '0;
        arg_hold  = '0;
        cs_lvl    = 1'b1;
        clk_lvl   = 1'b0;
    endfunction

    function void load_byte(logic [7:0] b);
        sh_out   = b;
        sh_in    = '0;
        bit_cnt  = '0;
        clk_lvl  = 1'b0;
        wait_cnt = half_r;
    endfunction

    function res_t predict_pins(req_t r);
        res_t       o;
        logic       fin;
        logic       acc;
        logic [7:0] rxv;
        logic [7:0] nb;
        fin = 1'b0;
        acc = 1'b0;
        rxv = '0;
        if (ph == PH_IDLE)
        begin
            case (r.kind)
                KIND_SET_CS:
                begin
                    cs_lvl = !r.chip_select;
                    acc = 1'b1;
                    fin = 1'b1;
                end
                KIND_CMD_FILL, KIND_CMD_CRC:
                begin
                    arg_hold  = r.argument;
                    byte_idx  = '0;
                    polls     = '0;
                    fill_left = (r.kind == KIND_CMD_FILL) ? r.extra_filler : r.tx_byte;
                    ph        = (r.kind == KIND_CMD_FILL) ? PH_CMD_FILL : PH_CMD_CRC;
                    load_byte(CMD_START | {2'b00, r.command_index});
                    acc = 1'b1;
                end
                KIND_WRITE:
                begin
                    ph = PH_WRITE;
                    load_byte(r.tx_byte);
                    acc = 1'b1;
                end
                KIND_READ:
                begin
                    ph = PH_READ;
                    load_byte(FILL_BYTE);
                    acc = 1'b1;
                end
                KIND_CLOCK:
                begin
                    ph = PH_CLOCK;
                    load_byte(FILL_BYTE);
                    bit_cnt = 3'd7;
                    acc = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (wait_cnt != 0)
        begin
            wait_cnt = wait_cnt - 1'b1;
        end
        else if (!clk_lvl)
        begin
            clk_lvl  = 1'b1;
            wait_cnt = half_r;
        end
        else
        begin
            sh_in  = {sh_in[6:0], r.miso};
            sh_out = {sh_out[6:0], 1'b1};
            if (bit_cnt < 3'd7)
            begin
                bit_cnt  = bit_cnt + 1'b1;
                clk_lvl  = 1'b0;
                wait_cnt = half_r;
            end
            else
            begin
                case (ph)
                    PH_CMD_FILL, PH_CMD_CRC:
                    begin
                        if (byte_idx < 3'd4)
                        begin
                            nb = arg_hold[31:24];
                            arg_hold = arg_hold << 8;
                            byte_idx = byte_idx + 1'b1;
                            load_byte(nb);
                        end
                        else if (byte_idx == 3'd4)
                        begin
                            nb = FILL_BYTE;
                            if (ph == PH_CMD_CRC)
                            begin
                                nb = fill_left;
                                fill_left = '0;
                            end
                            byte_idx = 3'd5;
                            load_byte(nb);
                        end
                        else
                        begin
                            polls = '0;
                            ph = (ph == PH_CMD_FILL && fill_left != 0) ? PH_FILLER : PH_POLL;
                            load_byte(FILL_BYTE);
                        end
                    end
                    PH_FILLER:
                    begin
                        fill_left = fill_left - 1'b1;
                        if (fill_left == 0)
                            ph = PH_POLL;
                        load_byte(FILL_BYTE);
                    end
                    PH_POLL:
                    begin
                        polls = polls + 1'b1;
                        if (sh_in != FILL_BYTE || polls >= POLL_LIMIT_DEF)
                        begin
                            fin = 1'b1;
                            rxv = sh_in;
                            ph  = PH_IDLE;
                        end
                        else
                        begin
                            load_byte(FILL_BYTE);
                        end
                    end
                    PH_READ:
                    begin
                        fin = 1'b1;
                        rxv = sh_in;
                        ph  = PH_IDLE;
                    end
                    default:
                    begin
                        fin = 1'b1;
                        ph  = PH_IDLE;
                    end
                endcase
            end
        end
        o.sclk     = clk_lvl;
        o.mosi     = (ph == PH_IDLE) ? 1'b1 : sh_out[7];
        o.cs_n     = cs_lvl;
        o.busy_res = (ph != PH_IDLE);
        o.done_res = fin;
        o.rx_byte  = rxv;
        o.accepted = acc;
        return o;
    endfunction

    function res_t unpack_pins(logic [15:0] d);
        res_t r;
        r.sclk     = d[0];
        r.mosi     = d[1];
        r.cs_n     = d[2];
        r.busy_res = d[3];
        r.done_res = d[4];
        r.rx_byte  = d[12:5];
        r.accepted = d[13];
        return r;
    endfunction

    function string fmt_pins(res_t r);
        return $sformatf("sclk=%b mosi=%b cs_n=%b busy=%b done=%b rx=%02h acc=%b",
                         r.sclk, r.mosi, r.cs_n, r.busy_res, r.done_res, r.rx_byte,
                         r.accepted);
    endfunction

    function int draw_gap();
        return (gappy && !calm) ? $urandom_range(0, 15) : 0;
    endfunction

    // card keeps MISO high until the chosen poll byte, then answers
    function logic card_miso();
        if (ph == PH_POLL && int'(polls) < resp_wait)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    function req_t noise_req();
        req_t r;
        r.kind          = 3'($urandom_range(0, 7));
        r.chip_select   = 1'($urandom_range(0, 1));
        r.tx_byte       = 8'($urandom);
        r.command_index = 6'($urandom);
        r.argument      = $urandom;
        r.extra_filler  = 8'($urandom);
        r.miso          = 1'b0;
        return r;
    endfunction

    function req_t rand_req();
        req_t r;
        int   w;
        r = noise_req();
        r.extra_filler = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 3));
        w = $urandom_range(0, 99);
        if (w < 20)
            r.kind = KIND_CMD_FILL;
        else if (w < 35)
            r.kind = KIND_CMD_CRC;
        else if (w < 50)
            r.kind = KIND_WRITE;
        else if (w < 65)
            r.kind = KIND_READ;
        else if (w < 75)
            r.kind = KIND_CLOCK;
        else if (w < 88)
            r.kind = KIND_SET_CS;
        else if (w < 94)
            r.kind = KIND_TICK;
        else
            r.kind = KIND_UNUSED;
        resp_wait = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
        return r;
    endfunction

    function void add_row(kind_t k, logic cs, logic [7:0] tx, logic [5:0] ci,
                          logic [31:0] a, logic [7:0] ef, int resp, bit run,
                          bit typed, res_t want);
        step_row_t s;
        s.rq    = '{k, cs, tx, ci, a, ef, 1'b0};
        s.resp  = resp;
        s.run   = run;
        s.typed = typed;
        s.want  = want;
        steps.push_back(s);
    endfunction

    task automatic send_tick(req_t rq, res_t want, bit typed);
        int   g;
        res_t p;
        if (n_items % 64 == 0)
            gappy = ($urandom_range(0, 4) == 0);
        g = draw_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {rq.miso, rq.extra_filler, rq.argument, rq.command_index,
                     rq.tx_byte, rq.chip_select};
        do
            @(posedge clk);
        while (!s_tready);
        p = predict_pins(rq);
        pending_pins.push_back(typed ? want : p);
        n_items++;
        if (p.accepted)
        begin
            n_taken++;
            if (rq.kind == KIND_CMD_FILL || rq.kind == KIND_CMD_CRC)
                n_cmds++;
        end
    endtask

    task automatic finish_request(bit noisy);
        req_t rq;
        while (ph != PH_IDLE)
        begin
            rq = noise_req();
            if (!noisy)
                rq.kind = KIND_TICK;
            rq.miso = card_miso();
            send_tick(rq, NO_RES, 1'b0);
        end
    endtask

    task automatic set_half(logic [15:0] v);
        s_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        half_r = v;
        n_cfg++;
    endtask

    // sends n ticks, then lets the running request finish
    task automatic random_run(int n);
        req_t rq;
        int   start;
        start = n_items;
        while (n_items - start < n)
        begin
            if (ph == PH_IDLE)
                rq = rand_req();
            else
                rq = noise_req();
            rq.miso = card_miso();
            send_tick(rq, NO_RES, 1'b0);
        end
        finish_request(1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #160_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result sink with random stalls
    initial
    begin
        int   g;
        res_t act;
        res_t want;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            g = draw_gap();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            act = unpack_pins(m_tdata);
            if (pending_pins.size() == 0)
            begin
                mism++;
                if (mism <= 10)
                    $display("unexpected result: %s", fmt_pins(act));
            end
            else
            begin
                want = pending_pins.pop_front();
                if (act !== want || m_tdata[15:14] !== 2'b00)
                begin
                    mism++;
                    if (mism <= 10)
                        $display("mismatch: expected %s, got %s (pad %b)",
                                 fmt_pins(want), fmt_pins(act), m_tdata[15:14]);
                end
            end
        end
    end

    initial
    begin
        req_t        rq;
        step_row_t   s;
        logic [15:0] half_list[5];
        int          i;
        half_list = '{16'd0, 16'd1, 16'd0, 16'd2, 16'd1};
        mism = 0;
        n_items = 0;
        n_taken = 0;
        n_cmds = 0;
        n_cfg = 0;
        gappy = 1'b0;
        calm = 1'b0;
        resp_wait = 0;
        pins_reset();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_TICK;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_half(16'd0);

        add_row(KIND_TICK, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 0, 1,
                res_t'{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        add_row(KIND_UNUSED, 1'b1, 8'hff, 6'd63, 32'hffffffff, 8'hff, 0, 0, 1,
                res_t'{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        add_row(KIND_SET_CS, 1'b1, 8'h00, 6'd0, 32'h0, 8'h00, 0, 0, 1,
                res_t'{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1});
        add_row(KIND_WRITE, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 1, 1,
                res_t'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1});
        add_row(KIND_WRITE, 1'b0, 8'hff, 6'd0, 32'h0, 8'h00, 0, 1, 0, NO_RES);
        add_row(KIND_READ, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 1, 0, NO_RES);
        add_row(KIND_CLOCK, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 1, 0, NO_RES);
        add_row(KIND_CMD_FILL, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 1, 1,
                res_t'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1});
        // card never answers: response stays all ones
        add_row(KIND_CMD_FILL, 1'b1, 8'hff, 6'd63, 32'hffffffff, 8'h02, 15, 1, 0, NO_RES);
        add_row(KIND_CMD_CRC, 1'b0, 8'h87, 6'd8, 32'h000001aa, 8'h00, 3, 1, 0, NO_RES);
        // answer on the last allowed poll byte
        add_row(KIND_CMD_CRC, 1'b0, 8'h00, 6'd0, 32'h0, 8'hff, 8, 1, 0, NO_RES);
        add_row(KIND_WRITE, 1'b0, 8'ha5, 6'd0, 32'h0, 8'h00, 0, 0, 0, NO_RES);
        add_row(KIND_READ, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 1, 0, NO_RES);
        add_row(KIND_SET_CS, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 0, 0, NO_RES);
        add_row(KIND_SET_CS, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 0, 0, NO_RES);
        add_row(KIND_TICK, 1'b0, 8'h00, 6'd0, 32'h0, 8'h00, 0, 0, 0, NO_RES);

        for (i = 0; i < steps.size(); i++)
        begin
            s = steps[i];
            resp_wait = s.resp;
            rq = s.rq;
            rq.miso = card_miso();
            send_tick(rq, s.want, s.typed);
            if (s.run)
                finish_request(1'b0);
        end

        for (i = 0; i < 5; i++)
        begin
            set_half(half_list[i]);
            random_run(100);
        end

        // widest half period: requests without bit timing still finish at once
        calm = 1'b1;
        set_half(16'hffff);
        rq = noise_req();
        rq.kind = KIND_SET_CS;
        rq.chip_select = 1'b1;
        send_tick(rq, NO_RES, 1'b0);
        rq = noise_req();
        rq.kind = KIND_TICK;
        send_tick(rq, NO_RES, 1'b0);
        calm = 1'b0;

        set_half(16'd1);
        random_run(40);

        s_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Run covered %0d ticks, %0d requests taken (%0d commands),",
                 n_items, n_taken, n_cmds);
        $display("%0d half-period writes, %0d mismatching results.", n_cfg, mism);
        if (mism == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
